// ===== sv/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, result kinds and sideband types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // coefficient and result widths
  localparam int COEF_W = 32;
  localparam int QUO_W  = 32;
  // discriminant b*b - 4ac, exact, signed
  localparam int D_W    = 66;
  // square root radicand (even width) and root
  localparam int RAD_W  = 66;
  localparam int ROOT_W = RAD_W / 2;
  // numerator -b +/- s, signed, and divisor 2a, signed
  localparam int NUM_W  = 35;
  localparam int DEN_W  = 33;
  // number of divider lanes (one per root)
  localparam int LANES  = 2;

  typedef enum logic [1:0] {
    KIND_DOUBLE  = 2'd0,
    KIND_REAL    = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_AZERO   = 2'd3
  } root_kind_e;

  // sideband that travels with an item through the square root pipeline
  typedef struct packed {
    root_kind_e               kind;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
  } sq_side_t;

  // unsigned quotient of one divider lane with sign and overflow
  typedef struct packed {
    logic [QUO_W-1:0] mag;
    logic             ovf;
    logic             neg;
  } div_res_t;

endpackage

// ===== sv/qrs_disc.sv =====
// ----------------------------------------------------------------------------
// qrs_disc
// Three-stage discriminant front end: products, b*b - 4ac, sign and magnitude.
// ----------------------------------------------------------------------------
module qrs_disc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_c_i,
  output logic                                valid_o,
  output logic [qrs_pkg::RAD_W-1:0]           rad_o,
  output qrs_pkg::sq_side_t                   side_o
);

  localparam int PROD_W = 2 * qrs_pkg::COEF_W;

  // stage 1: the two products
  logic                              v1_q;
  logic signed [PROD_W-1:0]          bb_q, ac_q;
  logic signed [qrs_pkg::COEF_W-1:0] a1_q, b1_q;
  logic signed [PROD_W-1:0]          bb_d, ac_d;

  assign bb_d = coef_b_i * coef_b_i;
  assign ac_d = coef_a_i * coef_c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q <= bb_d;
      ac_q <= ac_d;
      a1_q <= coef_a_i;
      b1_q <= coef_b_i;
    end
  end

  // stage 2: exact discriminant
  logic                              v2_q;
  logic signed [qrs_pkg::D_W-1:0]    d_q, d_d;
  logic signed [qrs_pkg::COEF_W-1:0] a2_q, b2_q;

  assign d_d = $signed({{(qrs_pkg::D_W-PROD_W){bb_q[PROD_W-1]}}, bb_q})
             - $signed({ac_q, 2'b00});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q  <= d_d;
      a2_q <= a1_q;
      b2_q <= b1_q;
    end
  end

  // stage 3: classify and take the magnitude
  logic                          v3_q;
  logic [qrs_pkg::RAD_W-1:0]     rad_q, rad_d;
  qrs_pkg::sq_side_t             side_q, side_d;

  always_comb begin
    side_d.coef_a = a2_q;
    side_d.coef_b = b2_q;
    if (a2_q == '0) begin
      side_d.kind = qrs_pkg::KIND_AZERO;
    end else if (d_q == '0) begin
      side_d.kind = qrs_pkg::KIND_DOUBLE;
    end else if (d_q[qrs_pkg::D_W-1]) begin
      side_d.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      side_d.kind = qrs_pkg::KIND_REAL;
    end
    rad_d = d_q[qrs_pkg::D_W-1] ? qrs_pkg::RAD_W'(-d_q) : qrs_pkg::RAD_W'(d_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = v3_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

// ===== sv/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qrs_pkg::RAD_W-1:0]     rad_i,
  input  qrs_pkg::sq_side_t             side_i,
  output logic                          valid_o,
  output logic [qrs_pkg::ROOT_W-1:0]    root_o,
  output qrs_pkg::sq_side_t             side_o
);

  localparam int STEPS = qrs_pkg::ROOT_W;
  localparam int REM_W = qrs_pkg::ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic                          v_q    [STEPS];
  logic [qrs_pkg::RAD_W-1:0]     x_q    [STEPS];
  logic [REM_W-1:0]              rem_q  [STEPS];
  logic [qrs_pkg::ROOT_W-1:0]    root_q [STEPS];
  qrs_pkg::sq_side_t             side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                       v_in;
    logic [qrs_pkg::RAD_W-1:0]  x_in;
    logic [REM_W-1:0]           rem_in;
    logic [qrs_pkg::ROOT_W-1:0] root_in;
    qrs_pkg::sq_side_t          side_in;
    logic [SH_W-1:0]            rem_sh, trial;
    logic [REM_W-1:0]           rem_d;
    logic [qrs_pkg::ROOT_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits and try root*4+1
    always_comb begin
      rem_sh = {rem_in, x_in[qrs_pkg::RAD_W-1 -: 2]};
      trial  = SH_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_in[qrs_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_in[qrs_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {x_in[qrs_pkg::RAD_W-3:0], 2'b00};
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

// ===== sv/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider: |num| * 2^FRAC_BITS / |den|, with
// overflow detection beyond 32 quotient bits and one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [qrs_pkg::NUM_W-1:0]   num_i [qrs_pkg::LANES],
  input  logic signed [qrs_pkg::DEN_W-1:0]   den_i,
  input  qrs_pkg::root_kind_e                kind_i,
  output logic                               valid_o,
  output qrs_pkg::div_res_t                  res_o [qrs_pkg::LANES],
  output qrs_pkg::root_kind_e                kind_o
);

  localparam int LN    = qrs_pkg::LANES;
  localparam int QW    = qrs_pkg::QUO_W;
  localparam int DW    = qrs_pkg::DEN_W;
  localparam int NS_W  = qrs_pkg::NUM_W + FRAC_BITS;
  localparam int HI_W  = NS_W - QW;
  localparam int CMP_W = (HI_W > DW) ? HI_W : DW;

  // stage m: sign and magnitude
  logic                      vm_q;
  logic [qrs_pkg::NUM_W-1:0] nmag_q [LN];
  logic                      neg_q  [LN];
  logic [DW-1:0]             dmag_q;
  qrs_pkg::root_kind_e       km_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      km_q   <= kind_i;
      for (int l = 0; l < LN; l++) begin
        nmag_q[l] <= num_i[l][qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-num_i[l])
                                                : qrs_pkg::NUM_W'(num_i[l]);
        neg_q[l]  <= num_i[l][qrs_pkg::NUM_W-1] ^ den_i[DW-1];
      end
    end
  end

  // stage o: scale, overflow check and first partial remainder
  logic                vo_q;
  logic [DW-1:0]       rem0_q [LN];
  logic [QW-1:0]       lo0_q  [LN];
  logic                ovf0_q [LN];
  logic                neg0_q [LN];
  logic [DW-1:0]       dmo_q;
  qrs_pkg::root_kind_e ko_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vm_q;
    end
  end

  for (genvar l = 0; l < LN; l++) begin : g_scale
    logic [NS_W-1:0] ns;
    logic [HI_W-1:0] hi;

    assign ns = {nmag_q[l], {FRAC_BITS{1'b0}}};
    assign hi = ns[NS_W-1:QW];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem0_q[l] <= DW'(hi);
        lo0_q[l]  <= ns[QW-1:0];
        ovf0_q[l] <= CMP_W'(hi) >= CMP_W'(dmag_q);
        neg0_q[l] <= neg_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmo_q <= dmag_q;
      ko_q  <= km_q;
    end
  end

  // quotient steps, most significant bit first
  logic                v_q    [QW];
  logic [DW-1:0]       dm_q   [QW];
  qrs_pkg::root_kind_e k_q    [QW];
  logic [DW-1:0]       rem_q  [QW][LN];
  logic [QW-1:0]       lo_q   [QW][LN];
  logic [QW-1:0]       quo_q  [QW][LN];
  logic                ovf_q  [QW][LN];
  logic                sgn_q  [QW][LN];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                v_in;
    logic [DW-1:0]       dm_in;
    qrs_pkg::root_kind_e k_in;

    if (k == 0) begin : g_first
      assign v_in  = vo_q;
      assign dm_in = dmo_q;
      assign k_in  = ko_q;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign dm_in = dm_q[k-1];
      assign k_in  = k_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dm_q[k] <= dm_in;
        k_q[k]  <= k_in;
      end
    end

    for (genvar l = 0; l < LN; l++) begin : g_lane
      logic [DW-1:0] rem_in;
      logic [QW-1:0] lo_in, quo_in;
      logic          ovf_in, sgn_in;
      logic [DW:0]   rem_sh;
      logic [DW-1:0] rem_d;
      logic          bit_d;

      if (k == 0) begin : g_first
        assign rem_in = rem0_q[l];
        assign lo_in  = lo0_q[l];
        assign quo_in = '0;
        assign ovf_in = ovf0_q[l];
        assign sgn_in = neg0_q[l];
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign lo_in  = lo_q[k-1][l];
        assign quo_in = quo_q[k-1][l];
        assign ovf_in = ovf_q[k-1][l];
        assign sgn_in = sgn_q[k-1][l];
      end

      // shift in the next dividend bit and subtract when it fits
      always_comb begin
        rem_sh = {rem_in, lo_in[QW-1]};
        if (rem_sh >= {1'b0, dm_in}) begin
          rem_d = DW'(rem_sh - {1'b0, dm_in});
          bit_d = 1'b1;
        end else begin
          rem_d = DW'(rem_sh);
          bit_d = 1'b0;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= rem_d;
          lo_q[k][l]  <= {lo_in[QW-2:0], 1'b0};
          quo_q[k][l] <= {quo_in[QW-2:0], bit_d};
          ovf_q[k][l] <= ovf_in;
          sgn_q[k][l] <= sgn_in;
        end
      end

      if (k == QW - 1) begin : g_out
        assign res_o[l].mag = quo_q[k][l];
        assign res_o[l].ovf = ovf_q[k][l];
        assign res_o[l].neg = sgn_q[k][l];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign kind_o  = k_q[QW-1];

endmodule

// ===== sv/quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one coefficient item per cycle and returns one result item per item,
// in order. The pipeline is made of the square root (one stage per root bit,
// 33) and the two parallel dividers (one stage per quotient bit, 32, plus two
// setup stages), with three discriminant stages, one numerator stage and one
// saturation stage. Throughput is one item per cycle; a two-entry output
// (last stage plus skid register) lets a new item in while a finished result
// waits, and the whole pipeline holds only while the skid register is full.
module quadratic_root_solver_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          root_kind_o,
  output logic signed [qrs_pkg::QUO_W-1:0]    root_one_o,
  output logic signed [qrs_pkg::QUO_W-1:0]    root_two_o,
  output logic                                saturated_o
);

  localparam int QW = qrs_pkg::QUO_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam logic [QW-1:0] MAX_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] MAX_NEG = {1'b1, {(QW-1){1'b0}}};

  logic en;
  logic skid_v_q, skid_v_d;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // discriminant
  logic                      dv;
  logic [qrs_pkg::RAD_W-1:0] rad;
  qrs_pkg::sq_side_t         dside;

  qrs_disc u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .valid_o  (dv),
    .rad_o    (rad),
    .side_o   (dside)
  );

  // square root of |d|
  logic                       sv;
  logic [qrs_pkg::ROOT_W-1:0] sroot;
  qrs_pkg::sq_side_t          sside;

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .rad_i   (rad),
    .side_i  (dside),
    .valid_o (sv),
    .root_o  (sroot),
    .side_o  (sside)
  );

  // numerators -b +/- s or -b and s, divisor 2a
  logic                              nv_q;
  logic signed [NW-1:0]              num_q [qrs_pkg::LANES];
  logic signed [qrs_pkg::DEN_W-1:0]  den_q;
  qrs_pkg::root_kind_e               nk_q;
  logic signed [NW-1:0]              negb, sext;

  assign negb = -$signed({{(NW-qrs_pkg::COEF_W){sside.coef_b[qrs_pkg::COEF_W-1]}},
                          sside.coef_b});
  assign sext = $signed({{(NW-qrs_pkg::ROOT_W){1'b0}}, sroot});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en) begin
      nv_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= $signed({sside.coef_a, 1'b0});
      nk_q  <= sside.kind;
      if (sside.kind == qrs_pkg::KIND_COMPLEX) begin
        num_q[0] <= negb;
        num_q[1] <= sext;
      end else begin
        num_q[0] <= negb + sext;
        num_q[1] <= negb - sext;
      end
    end
  end

  // scaled division, both roots side by side
  logic                 qv;
  qrs_pkg::div_res_t    qres [qrs_pkg::LANES];
  qrs_pkg::root_kind_e  qk;

  qrs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .kind_i  (nk_q),
    .valid_o (qv),
    .res_o   (qres),
    .kind_o  (qk)
  );

  // saturation to the signed output range
  logic [QW-1:0] root_d [qrs_pkg::LANES];
  logic          sat_d  [qrs_pkg::LANES];

  always_comb begin
    for (int l = 0; l < qrs_pkg::LANES; l++) begin
      if (qres[l].neg) begin
        if (qres[l].ovf || (qres[l].mag[QW-1] && (qres[l].mag[QW-2:0] != '0))) begin
          root_d[l] = MAX_NEG;
          sat_d[l]  = 1'b1;
        end else begin
          root_d[l] = -qres[l].mag;
          sat_d[l]  = 1'b0;
        end
      end else begin
        if (qres[l].ovf || qres[l].mag[QW-1]) begin
          root_d[l] = MAX_POS;
          sat_d[l]  = 1'b1;
        end else begin
          root_d[l] = qres[l].mag;
          sat_d[l]  = 1'b0;
        end
      end
    end
  end

  // last pipeline stage
  logic                fin_v_q;
  qrs_pkg::root_kind_e fin_k_q;
  logic [QW-1:0]       fin_r1_q, fin_r2_q;
  logic                fin_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= qv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_k_q <= qk;
      if (qk == qrs_pkg::KIND_AZERO) begin
        fin_r1_q <= '0;
        fin_r2_q <= '0;
        fin_s_q  <= 1'b0;
      end else begin
        fin_r1_q <= root_d[0];
        fin_r2_q <= root_d[1];
        fin_s_q  <= sat_d[0] | sat_d[1];
      end
    end
  end

  // skid register catches the last stage when the output stalls
  qrs_pkg::root_kind_e skid_k_q;
  logic [QW-1:0]       skid_r1_q, skid_r2_q;
  logic                skid_s_q;

  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q && out_ready_i) begin
      skid_v_d = 1'b0;
    end else if (en && fin_v_q && !out_ready_i) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skid_k_q  <= fin_k_q;
      skid_r1_q <= fin_r1_q;
      skid_r2_q <= fin_r2_q;
      skid_s_q  <= fin_s_q;
    end
  end

  // output selection
  assign out_valid_o = skid_v_q | fin_v_q;
  assign root_kind_o = skid_v_q ? skid_k_q : fin_k_q;
  assign root_one_o  = skid_v_q ? skid_r1_q : fin_r1_q;
  assign root_two_o  = skid_v_q ? skid_r2_q : fin_r2_q;
  assign saturated_o = skid_v_q ? skid_s_q : fin_s_q;

endmodule

// ===== sv/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        root_kind_o,
  input logic signed [qrs_pkg::QUO_W-1:0]  root_one_o,
  input logic signed [qrs_pkg::QUO_W-1:0]  root_two_o,
  input logic                              saturated_o
);

  localparam logic [qrs_pkg::QUO_W-1:0] MAX_POS = {1'b0, {(qrs_pkg::QUO_W-1){1'b1}}};
  localparam logic [qrs_pkg::QUO_W-1:0] MAX_NEG = {1'b1, {(qrs_pkg::QUO_W-1){1'b0}}};

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_one_o)
      && $stable(root_two_o) && $stable(root_kind_o) && $stable(saturated_o))
    else $error("result item changed while stalled");

  // zero a gives an all-zero item
  a_azero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_kind_o == qrs_pkg::KIND_AZERO) |->
      (root_one_o == '0) && (root_two_o == '0) && !saturated_o)
    else $error("zero a item not cleared");

  // a double root repeats itself
  a_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_kind_o == qrs_pkg::KIND_DOUBLE) |-> root_one_o == root_two_o)
    else $error("double root halves differ");

  // a clipped item carries a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (root_one_o == MAX_POS) || (root_one_o == MAX_NEG)
      || (root_two_o == MAX_POS) || (root_two_o == MAX_NEG))
    else $error("saturated flag without a clipped root");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);
